// ===== src/sts_pkg.sv =====
// Package for the sorted table search block: action and status codes, word widths,
// controller state type and default table depth. No dependencies.
package sts_pkg;

  // Default number of table entries
  localparam int unsigned DEPTH_DEFAULT = 1024;

  // Word widths fixed by the interface
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 10;

  // Command codes carried by action_i
  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_SEARCH = 2'd2
  } action_e;

  // Result codes carried by status_o
  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_APPENDED  = 3'd2,
    ST_FULL      = 3'd3,
    ST_CLEARED   = 3'd4
  } status_e;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_e;

endpackage

// ===== src/sts_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/sorted_table_binary_search.sv =====
// Sorted table with binary search. Clear, append, unused codes and empty-table
// searches finish in the accept cycle; the result strobes in the next cycle and busy
// stays low, so they can follow every cycle. Other searches are busy while probing
// (at most floor(log2(count))+1 probes, each a RAM read loop: compare, next
// midpoint, next read in the same cycle) and strobe results in the cycle after the
// last probe. Reset clears control registers; entries are undefined until appended.
module sorted_table_binary_search #(
  parameter int unsigned DEPTH = sts_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action_i,
  input  logic signed [sts_pkg::VALUE_W-1:0] value_i,
  output logic                        valid_o,
  output logic [2:0]                  status_o,
  output logic [sts_pkg::POS_W-1:0]   position_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sts_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] lo_q, lo_d;
  logic [CNT_W-1:0] hi_q, hi_d;
  logic [CNT_W-1:0] mid_q, mid_d;
  logic signed [sts_pkg::VALUE_W-1:0] key_q, key_d;

  logic                      valid_q, valid_d;
  sts_pkg::status_e          status_q, status_d;
  logic [sts_pkg::POS_W-1:0] pos_q, pos_d;

  logic accept;
  logic probe_hit;
  logic probe_lt;
  logic search_done;
  logic [CNT_W-1:0] lo_n, hi_n, mid_n;
  logic [31:0] mid_ext;

  logic                             ram_we;
  logic [IDX_W-1:0]                 ram_waddr;
  logic signed [sts_pkg::VALUE_W-1:0] ram_rdata;

  assign accept = start && (state_q == sts_pkg::S_IDLE);
  assign busy   = (state_q != sts_pkg::S_IDLE);

  // Table storage
  sts_ram #(
    .WIDTH(sts_pkg::VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(value_i),
    .raddr_i(mid_d[IDX_W-1:0]),
    .rdata_o(ram_rdata)
  );

  // Probe compare and range narrowing for the word just read
  always_comb begin
    probe_hit = (key_q == ram_rdata);
    probe_lt  = (key_q < ram_rdata);
    lo_n      = lo_q;
    hi_n      = hi_q;
    if (probe_lt) begin
      hi_n = mid_q;
    end else begin
      lo_n = mid_q + CNT_W'(1);
    end
    search_done = probe_hit || (lo_n >= hi_n);
    mid_n       = lo_n + ((hi_n - lo_n - CNT_W'(1)) >> 1);
  end

  assign mid_ext = 32'(mid_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sts_pkg::S_IDLE: begin
        if (accept && (action_i == sts_pkg::ACT_SEARCH) && (count_q != '0)) begin
          state_d = sts_pkg::S_SEARCH;
        end
      end
      sts_pkg::S_SEARCH: begin
        if (search_done) begin
          state_d = sts_pkg::S_IDLE;
        end
      end
      default: state_d = sts_pkg::S_IDLE;
    endcase
  end

  // Datapath and result words
  always_comb begin
    count_d   = count_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    key_d     = key_q;
    valid_d   = 1'b0;
    status_d  = status_q;
    pos_d     = pos_q;
    ram_we    = 1'b0;
    ram_waddr = count_q[IDX_W-1:0];
    case (state_q)
      sts_pkg::S_IDLE: begin
        if (accept) begin
          valid_d  = 1'b1;
          pos_d    = '0;
          status_d = sts_pkg::ST_NOT_FOUND;
          case (action_i)
            sts_pkg::ACT_CLEAR: begin
              count_d  = '0;
              status_d = sts_pkg::ST_CLEARED;
            end
            sts_pkg::ACT_APPEND: begin
              if (count_q < CNT_W'(DEPTH)) begin
                ram_we   = 1'b1;
                count_d  = count_q + CNT_W'(1);
                status_d = sts_pkg::ST_APPENDED;
              end else begin
                status_d = sts_pkg::ST_FULL;
              end
            end
            sts_pkg::ACT_SEARCH: begin
              // first read goes out now; empty table answers at once
              key_d = value_i;
              lo_d  = '0;
              hi_d  = count_q;
              mid_d = (count_q - CNT_W'(1)) >> 1;
              if (count_q != '0) begin
                valid_d = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      sts_pkg::S_SEARCH: begin
        lo_d  = lo_n;
        hi_d  = hi_n;
        mid_d = mid_n;
        if (probe_hit) begin
          valid_d  = 1'b1;
          status_d = sts_pkg::ST_FOUND;
          pos_d    = mid_ext[sts_pkg::POS_W-1:0];
          mid_d    = mid_q;
        end else if (search_done) begin
          valid_d  = 1'b1;
          status_d = sts_pkg::ST_NOT_FOUND;
          pos_d    = '0;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sts_pkg::S_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    key_q    <= key_d;
    status_q <= status_d;
    pos_q    <= pos_d;
  end

  assign valid_o    = valid_q;
  assign status_o   = status_q;
  assign position_o = pos_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above table depth");

  a_count_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sts_pkg::S_SEARCH) |=> $stable(count_q))
    else $error("entry count changed during a search");

  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (action_i != sts_pkg::ACT_SEARCH)) |=> (valid_o && !busy))
    else $error("clear or append gave no result word in the next cycle");

  a_found_from_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o == sts_pkg::ST_FOUND)) |-> ($past(state_q) == sts_pkg::S_SEARCH))
    else $error("found result without a probe");

endmodule

// ===== dv/sorted_table_binary_search_tb.sv =====
// Self-checking testbench for sorted_table_binary_search: drives clear, append, search
// and unused-code words, predicts each result with a scoreboard class, checks every strobe.
// Depends on sts_pkg and the sorted_table_binary_search RTL only.
module sorted_table_binary_search_tb;

  localparam int unsigned TABLE_DEPTH    = sts_pkg::DEPTH_DEFAULT;
  localparam logic [1:0]  ACT_UNUSED     = 2'd3;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          RANDOM_WORDS   = 900;

  // Q16.16 corner values
  localparam logic signed [31:0] Q_MIN     = 32'sh8000_0000;
  localparam logic signed [31:0] Q_MAX     = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_NEG_ONE = 32'shffff_0000;
  localparam logic signed [31:0] Q_ONE     = 32'sh0001_0000;

  typedef struct packed {
    sts_pkg::status_e status;
    logic [9:0]       position;
  } lookup_result_t;

  // Table model plus queue of pending lookup results
  class search_scoreboard;
    logic signed [31:0] entries [TABLE_DEPTH];
    int unsigned        fill;
    lookup_result_t     expected_q[$];
    int unsigned        errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    // Apply one accepted word to the table and queue its result
    function void note_word(logic [1:0] act, logic signed [31:0] val);
      lookup_result_t r;
      int             lo;
      int             hi;
      int             mid;
      bit             hit;
      r.status   = sts_pkg::ST_NOT_FOUND;
      r.position = '0;
      case (act)
        sts_pkg::ACT_CLEAR: begin
          fill     = 0;
          r.status = sts_pkg::ST_CLEARED;
        end
        sts_pkg::ACT_APPEND: begin
          if (fill < TABLE_DEPTH) begin
            entries[fill] = val;
            fill++;
            r.status = sts_pkg::ST_APPENDED;
          end else begin
            r.status = sts_pkg::ST_FULL;
          end
        end
        sts_pkg::ACT_SEARCH: begin
          // classic binary search, first matching midpoint wins
          lo  = 0;
          hi  = int'(fill) - 1;
          hit = 1'b0;
          while (!hit && lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (val < entries[mid]) begin
              hi = mid - 1;
            end else if (val > entries[mid]) begin
              lo = mid + 1;
            end else begin
              hit        = 1'b1;
              r.status   = sts_pkg::ST_FOUND;
              r.position = mid[9:0];
            end
          end
        end
        default: ;  // unused code: not found, table untouched
      endcase
      expected_q = {expected_q, r};
    endfunction

    // Compare one strobed result with the oldest expectation
    function void check_word(logic [2:0] st, logic [9:0] pos);
      lookup_result_t r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word: status %0d position %0d", $time, st, pos);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      if (st !== r.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, r.status, st);
        errors++;
      end
      if (pos !== r.position) begin
        $display("%0t: position mismatch: expected %0d actual %0d", $time, r.position, pos);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                               clk_i;
  logic                               rst_ni;
  logic                               start;
  logic                               busy;
  logic [1:0]                         action_i;
  logic signed [sts_pkg::VALUE_W-1:0] value_i;
  logic                               valid_o;
  logic [2:0]                         status_o;
  logic [sts_pkg::POS_W-1:0]          position_o;

  search_scoreboard   sb = new();
  int                 burst_left;
  bit                 no_gaps;
  int                 words_sent;
  int                 stall_cycles;
  logic signed [31:0] loaded[$];

  sorted_table_binary_search #(
    .DEPTH(TABLE_DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .action_i   (action_i),
    .value_i    (value_i),
    .valid_o    (valid_o),
    .status_o   (status_o),
    .position_o (position_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      sb.check_word(status_o, position_o);
    end
  end

  // Watchdog: cycles with neither a word accepted nor a result strobed
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, no handshake for %0d cycles", $time, stall_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Drop start for the pause given by n, with junk on the payload
  task automatic pause_sender(int n);
    @(negedge clk_i);
    start    <= 1'b0;
    action_i <= 2'($urandom());
    value_i  <= $urandom();
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Present one word and hold it until accepted
  task automatic send_word(logic [1:0] act, logic signed [31:0] val);
    if (!no_gaps && burst_left == 0) begin
      pause_sender($urandom_range(1, 12));
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    start    <= 1'b1;
    action_i <= act;
    value_i  <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_word(act, val);
    words_sent++;
  endtask

  // Hold off until every queued result has been seen
  task automatic wait_all_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Append n values, mostly ascending; dense runs give duplicates and neighbors
  task automatic load_run(int n, bit dense);
    longint             cur;
    longint             step_max;
    logic signed [31:0] val;
    step_max = 64'sh1_0000_0000 / (n + 2);
    if ($urandom_range(0, 3) == 0) cur = longint'(Q_MIN);
    else if ($urandom_range(0, 1) == 0) cur = longint'($signed($urandom()));
    else cur = longint'(Q_MIN) + longint'($urandom_range(0, 32'(step_max)));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 29) == 0) begin
        // noise: unused code
        send_word(ACT_UNUSED, $urandom());
      end
      if ($urandom_range(0, 24) == 0) begin
        // noise: out-of-order value
        val = $urandom();
      end else begin
        if (dense) cur += $urandom_range(0, 2);
        else cur += longint'($urandom_range(0, 32'(2 * step_max - 1)));
        if (cur > longint'(Q_MAX)) cur = longint'(Q_MAX);
        val = cur[31:0];
      end
      send_word(sts_pkg::ACT_APPEND, val);
      if (loaded.size() < TABLE_DEPTH) loaded = {loaded, val};
    end
  endtask

  // Searches: mostly stored keys, then neighbors, random keys and corners, plus unused-code words
  task automatic search_mix(int n);
    logic signed [31:0] key;
    int                 pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (loaded.size() > 0) key = loaded[$urandom_range(0, loaded.size() - 1)];
      else key = $urandom();
      case (pick)
        5:       key = key + 1;
        6:       key = key - 1;
        7:       key = $urandom();
        8: begin
          case ($urandom_range(0, 3))
            0:       key = Q_MIN;
            1:       key = Q_MAX;
            2:       key = '0;
            default: key = '1;
          endcase
        end
        default: ;
      endcase
      if (pick == 9) send_word(ACT_UNUSED, $urandom());
      else send_word(sts_pkg::ACT_SEARCH, key);
    end
  endtask

  // One table load followed by a batch of searches
  task automatic run_episode(bit fill_up);
    int n;
    no_gaps = ($urandom_range(0, 3) == 0);
    if (fill_up || $urandom_range(0, 7) != 0) begin
      send_word(sts_pkg::ACT_CLEAR, $urandom());
      loaded.delete();
    end
    if (fill_up) n = TABLE_DEPTH + 3;
    else if ($urandom_range(0, 3) == 0) n = $urandom_range(0, 200);
    else n = $urandom_range(0, 24);
    load_run(n, !fill_up && $urandom_range(0, 2) == 0);
    search_mix(fill_up ? 60 : $urandom_range(1, 30));
    if ($urandom_range(0, 3) == 0) wait_all_results();
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    action_i     = sts_pkg::ACT_CLEAR;
    value_i      = '0;
    burst_left   = 0;
    no_gaps      = 1'b0;
    words_sent   = 0;
    stall_cycles = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty table, unused code, corner values, duplicates, unsorted entry
    send_word(sts_pkg::ACT_SEARCH, '0);
    send_word(ACT_UNUSED, '1);
    send_word(sts_pkg::ACT_CLEAR, '0);
    send_word(sts_pkg::ACT_SEARCH, Q_MAX);
    send_word(sts_pkg::ACT_APPEND, Q_MIN);
    send_word(sts_pkg::ACT_APPEND, Q_NEG_ONE);
    send_word(sts_pkg::ACT_APPEND, '0);
    send_word(sts_pkg::ACT_APPEND, '0);
    send_word(sts_pkg::ACT_APPEND, Q_ONE);
    send_word(sts_pkg::ACT_APPEND, Q_MAX);
    send_word(sts_pkg::ACT_SEARCH, Q_MIN);
    send_word(sts_pkg::ACT_SEARCH, Q_MAX);
    send_word(sts_pkg::ACT_SEARCH, '0);
    send_word(sts_pkg::ACT_SEARCH, Q_NEG_ONE);
    send_word(sts_pkg::ACT_SEARCH, 32'sh0000_8000);
    send_word(sts_pkg::ACT_SEARCH, 32'sh8000_0001);
    send_word(sts_pkg::ACT_APPEND, 32'sh0001_8000);
    send_word(sts_pkg::ACT_SEARCH, 32'sh0001_8000);
    send_word(ACT_UNUSED, '0);
    send_word(sts_pkg::ACT_CLEAR, '1);
    send_word(sts_pkg::ACT_SEARCH, Q_MIN);
    wait_all_results();

    // Random episodes
    while (words_sent < RANDOM_WORDS) run_episode(1'b0);

    wait_all_results();
    repeat (16) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
